// ----- rtl/assert_macros.svh -----
// Assertion helpers for the bank mapper RTL.
// Used only by the top level; needs a clock and an active-high reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/sbsm_pkg.sv -----
// Shared types and constants of the serial bank switch mapper.
// No dependencies; imported by every module of the block.
package sbsm_pkg;

  localparam int PRG_ADDR_BITS = 19;
  localparam int CHR_ADDR_BITS = 17;
  localparam int MEM_ADDR_W    = 19;
  localparam int CHR_OFF_W     = 17;

  localparam logic [1:0] CMD_CPU_RD = 2'd0;
  localparam logic [1:0] CMD_CPU_WR = 2'd1;
  localparam logic [1:0] CMD_PPU_RD = 2'd2;
  localparam logic [1:0] CMD_PPU_WR = 2'd3;

  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_PRG_RAM = 2'd1;
  localparam logic [1:0] TGT_PRG_ROM = 2'd2;
  localparam logic [1:0] TGT_CHR     = 2'd3;

  localparam logic [1:0] REG_PRG_SIZE    = 2'd0;
  localparam logic [1:0] REG_CHR_SIZE    = 2'd1;
  localparam logic [1:0] REG_CHR_IS_RAM  = 2'd2;
  localparam logic [1:0] REG_FOUR_SCREEN = 2'd3;

  // serial register targets, address bits 14..13
  localparam logic [1:0] SEL_CONTROL = 2'd0;
  localparam logic [1:0] SEL_CHR0    = 2'd1;
  localparam logic [1:0] SEL_CHR1    = 2'd2;
  localparam logic [1:0] SEL_PRG     = 2'd3;

  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

  localparam logic [4:0] SHIFT_EMPTY = 5'h10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic        back_to_back;
  } in_t;

  typedef struct packed {
    logic [1:0]            target;
    logic [MEM_ADDR_W-1:0] mem_addr;
    logic                  write_enable;
    logic [7:0]            data_out;
    logic [1:0]            mirroring;
  } out_t;

  typedef struct packed {
    logic [4:0] prg_size_log2;
    logic [4:0] chr_size_log2;
    logic       chr_is_ram;
    logic       four_screen;
  } cfg_t;

endpackage

// ----- rtl/serial_bank_switch_mapper.sv -----
// Serial bank switch mapper: input register, translation, result register.
// Accepted beat: input register, then its result in the out_data register.
// Throughput: one beat per cycle unless stalled; single translation pass.
// Reset (rst, synchronous): pipeline empty, registers and mapper state at
// power-on values; no clearing pass, beats accepted right after reset.
`include "assert_macros.svh"

module serial_bank_switch_mapper
  import sbsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  in_t  s1_item;
  logic s1_valid;
  logic s2_ready, s1_fire, in_accept;
  out_t res;

  assign s2_ready  = !out_valid || !out_stall;
  assign s1_fire   = s1_valid && s2_ready;
  assign in_stall  = s1_valid && !s2_ready;
  assign in_accept = in_valid && !in_stall;

  sbsm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sbsm_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (s1_item),
    .fire (s1_fire),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (s2_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= res;
    end
  end

  `ASSERT_NEXT(a_accept_loads, clk, rst, in_accept, s1_valid)
  `ASSERT_NEXT(a_s1_holds, clk, rst, s1_valid && !s2_ready,
               s1_valid && $stable(s1_item))
  `ASSERT_IMPLY(a_stall_needs_full, clk, rst, in_stall, s1_valid && out_valid)
  `ASSERT_IMPLY(a_we_target, clk, rst, out_valid && out_data.write_enable,
                out_data.target == TGT_PRG_RAM || out_data.target == TGT_CHR)

endmodule

// ----- rtl/sbsm_cfg.sv -----
// APB register file of the mapper: ROM sizes, CHR RAM flag, four-screen flag.
// Depends on sbsm_pkg.
module sbsm_cfg
  import sbsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prg_size_log2 <= 5'd18;
      cfg.chr_size_log2 <= 5'd13;
      cfg.chr_is_ram    <= 1'b1;
      cfg.four_screen   <= 1'b0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_PRG_SIZE:    cfg.prg_size_log2 <= pwdata[4:0];
        REG_CHR_SIZE:    cfg.chr_size_log2 <= pwdata[4:0];
        REG_CHR_IS_RAM:  cfg.chr_is_ram    <= pwdata[0];
        REG_FOUR_SCREEN: cfg.four_screen   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PRG_SIZE:    prdata = {27'd0, cfg.prg_size_log2};
      REG_CHR_SIZE:    prdata = {27'd0, cfg.chr_size_log2};
      REG_CHR_IS_RAM:  prdata = {31'd0, cfg.chr_is_ram};
      REG_FOUR_SCREEN: prdata = {31'd0, cfg.four_screen};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ----- rtl/sbsm_core.sv -----
// Mapper state (serial register, bank and mode registers) and the
// single-pass address translation. Depends on sbsm_pkg.
module sbsm_core
  import sbsm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  in_t  item,
  input  logic fire,
  output out_t res
);

  // CHR bank registers keep the raw 5-bit serial value, PRG bank its low 4 bits;
  // shifting and masking happen at translation time
  logic [4:0] load_shift, load_shift_next;
  logic [1:0] prg_mode, prg_mode_next;
  logic       chr_single, chr_single_next;
  logic [4:0] chr_lo, chr_lo_next;
  logic [4:0] chr_hi, chr_hi_next;
  logic [3:0] prg_bank, prg_bank_next;
  logic       outer_bank, outer_bank_next;
  logic [1:0] mirror_mode, mirror_mode_next;

  logic [4:0]            prg_l, chr_l;
  logic [19:0]           prg_size;
  logic [MEM_ADDR_W-1:0] prg_mask;
  logic [19:0]           last_full;
  logic [3:0]            last_bank;
  logic [17:0]           prg_off;
  logic [MEM_ADDR_W-1:0] prg_addr;
  logic [17:0]           chr_size;
  logic [CHR_OFF_W-1:0]  chr_mask, chr_off;
  logic                  big;
  logic                  is_cpu, in_ram, in_rom;
  logic [4:0]            shifted;

  // size saturation
  always_comb begin
    if (cfg.prg_size_log2 < 5'd14)
      prg_l = 5'd14;
    else if (cfg.prg_size_log2 > 5'(PRG_ADDR_BITS))
      prg_l = 5'(PRG_ADDR_BITS);
    else
      prg_l = cfg.prg_size_log2;
    if (cfg.chr_size_log2 < 5'd13)
      chr_l = 5'd13;
    else if (cfg.chr_size_log2 > 5'(CHR_ADDR_BITS))
      chr_l = 5'(CHR_ADDR_BITS);
    else
      chr_l = cfg.chr_size_log2;
  end

  assign prg_size  = 20'd1 << prg_l;
  assign prg_mask  = MEM_ADDR_W'(prg_size - 20'd1);
  assign last_full = prg_size - 20'h04000;
  assign last_bank = last_full[17:14];
  assign big       = prg_l > 5'd18;
  assign chr_size  = 18'd1 << chr_l;
  assign chr_mask  = CHR_OFF_W'(chr_size - 18'd1);

  // PRG offset; every bank base has zero low bits, so sums are concatenations
  always_comb begin
    case (prg_mode)
      PRG_MODE_FIX_LAST:
        prg_off = item.addr[14] ? {last_bank, item.addr[13:0]}
                                : {prg_bank, item.addr[13:0]};
      PRG_MODE_FIX_FIRST:
        prg_off = item.addr[14] ? {prg_bank, item.addr[13:0]}
                                : {4'd0, item.addr[13:0]};
      default:
        prg_off = {prg_bank[3:1], item.addr[14:0]};
    endcase
  end

  assign prg_addr = {outer_bank, prg_off} & prg_mask;

  always_comb begin
    if (chr_single)
      chr_off = {chr_lo[4:1], item.addr[12:0]};
    else if (item.addr[12])
      chr_off = {chr_hi, item.addr[11:0]};
    else
      chr_off = {chr_lo, item.addr[11:0]};
  end

  assign is_cpu  = (item.cmd == CMD_CPU_RD) || (item.cmd == CMD_CPU_WR);
  assign in_ram  = item.addr[15:13] == 3'b011;
  assign in_rom  = item.addr[15];
  assign shifted = {item.data[0], load_shift[4:1]};

  // serial loading register and commits
  always_comb begin
    load_shift_next  = load_shift;
    prg_mode_next    = prg_mode;
    chr_single_next  = chr_single;
    chr_lo_next      = chr_lo;
    chr_hi_next      = chr_hi;
    prg_bank_next    = prg_bank;
    outer_bank_next  = outer_bank;
    mirror_mode_next = mirror_mode;
    if (item.cmd == CMD_CPU_WR && in_rom && !item.back_to_back) begin
      if (item.data[7]) begin
        load_shift_next = SHIFT_EMPTY;
        prg_mode_next   = PRG_MODE_FIX_LAST;
      end else if (load_shift[0]) begin
        load_shift_next = SHIFT_EMPTY;
        case (item.addr[14:13])
          SEL_CONTROL: begin
            if (!cfg.four_screen) mirror_mode_next = shifted[1:0];
            prg_mode_next   = shifted[3:2];
            chr_single_next = !shifted[4];
          end
          SEL_CHR0: begin
            chr_lo_next = shifted;
            if (big) outer_bank_next = shifted[4];
          end
          SEL_CHR1: begin
            chr_hi_next = shifted;
            if (!chr_single && big) outer_bank_next = shifted[4];
          end
          default: prg_bank_next = shifted[3:0];
        endcase
      end else begin
        load_shift_next = shifted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_shift  <= SHIFT_EMPTY;
      prg_mode    <= PRG_MODE_FIX_LAST;
      chr_single  <= 1'b0;
      chr_lo      <= 5'd0;
      chr_hi      <= 5'd0;
      prg_bank    <= 4'd0;
      outer_bank  <= 1'b0;
      mirror_mode <= 2'd0;
    end else if (fire) begin
      load_shift  <= load_shift_next;
      prg_mode    <= prg_mode_next;
      chr_single  <= chr_single_next;
      chr_lo      <= chr_lo_next;
      chr_hi      <= chr_hi_next;
      prg_bank    <= prg_bank_next;
      outer_bank  <= outer_bank_next;
      mirror_mode <= mirror_mode_next;
    end
  end

  always_comb begin
    res.target       = TGT_NONE;
    res.mem_addr     = '0;
    res.write_enable = 1'b0;
    res.data_out     = item.data;
    res.mirroring    = mirror_mode_next;   // mirroring as left by this beat
    if (is_cpu) begin
      if (in_ram) begin
        res.target       = TGT_PRG_RAM;
        res.mem_addr     = MEM_ADDR_W'(item.addr[12:0]);
        res.write_enable = item.cmd == CMD_CPU_WR;
      end else if (in_rom && item.cmd == CMD_CPU_RD) begin
        res.target   = TGT_PRG_ROM;
        res.mem_addr = prg_addr;
      end
    end else begin
      res.target       = TGT_CHR;
      res.mem_addr     = MEM_ADDR_W'(chr_off & chr_mask);
      res.write_enable = (item.cmd == CMD_PPU_WR) && cfg.chr_is_ram;
    end
  end

endmodule

// ----- bench/serial_bank_switch_mapper_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for serial_bank_switch_mapper: directed and randomised bus
// accesses against a bit-accurate mapper predictor, with bursty sender, stalling
// receiver and APB setup. Depends on sbsm_pkg and the mapper RTL only.
module serial_bank_switch_mapper_test
  import sbsm_pkg::*;
();

  localparam int IDLE_LIMIT = 3000;
  localparam int NUM_PHASES = 10;
  localparam int RANDOM_PER_PHASE = 95;
  localparam int IN_W = $bits(in_t);

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  serial_bank_switch_mapper dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // mapper shadow: configuration and banking state
  cfg_t                  mapper_cfg;
  logic [4:0]            load_shift;
  logic [1:0]            prg_mode;
  logic                  chr_single;
  logic [CHR_OFF_W-1:0]  chr_bank_lo;
  logic [CHR_OFF_W-1:0]  chr_bank_hi;
  logic [MEM_ADDR_W-1:0] prg_bank;
  logic                  outer_bank;
  logic [1:0]            mirror_mode;

  in_t  pending_accesses[$];
  out_t expected_beats[$];
  int unsigned queued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatches = 0;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < 100)
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic void reset_mapper_model();
    mapper_cfg.prg_size_log2 = 5'd18;
    mapper_cfg.chr_size_log2 = 5'd13;
    mapper_cfg.chr_is_ram    = 1'b1;
    mapper_cfg.four_screen   = 1'b0;
    load_shift  = SHIFT_EMPTY;
    prg_mode    = PRG_MODE_FIX_LAST;
    chr_single  = 1'b0;
    chr_bank_lo = '0;
    chr_bank_hi = '0;
    prg_bank    = '0;
    outer_bank  = 1'b0;
    mirror_mode = 2'd0;
  endfunction

  function automatic int unsigned prg_rom_bytes();
    int unsigned l;
    l = 32'(mapper_cfg.prg_size_log2);
    if (l < 14) l = 14;
    if (l > PRG_ADDR_BITS) l = PRG_ADDR_BITS;
    return 32'd1 << l;
  endfunction

  function automatic int unsigned chr_mem_bytes();
    int unsigned l;
    l = 32'(mapper_cfg.chr_size_log2);
    if (l < 13) l = 13;
    if (l > CHR_ADDR_BITS) l = CHR_ADDR_BITS;
    return 32'd1 << l;
  endfunction

  function automatic void commit_serial(logic [1:0] sel, logic [4:0] v);
    logic big;
    big = prg_rom_bytes() > 32'h40000;
    case (sel)
      SEL_CONTROL: begin
        if (!mapper_cfg.four_screen) mirror_mode = v[1:0];
        prg_mode   = v[3:2];
        chr_single = !v[4];
      end
      SEL_CHR0: begin
        chr_bank_lo = {v, 12'h000};
        if (big) outer_bank = v[4];
      end
      SEL_CHR1: begin
        // stored in either CHR mode, outer bank only follows in 4K mode
        chr_bank_hi = {v, 12'h000};
        if (!chr_single && big) outer_bank = v[4];
      end
      default: begin
        prg_bank = {1'b0, v[3:0], 14'h0000};
      end
    endcase
  endfunction

  function automatic void serial_load(in_t acc);
    logic [4:0] shifted;
    if (acc.back_to_back) begin
      // write in the cycle after a write: dropped
    end else if (acc.data[7]) begin
      load_shift = SHIFT_EMPTY;
      prg_mode   = PRG_MODE_FIX_LAST;
    end else begin
      shifted = {acc.data[0], load_shift[4:1]};
      if (load_shift[0]) begin
        commit_serial(acc.addr[14:13], shifted);
        load_shift = SHIFT_EMPTY;
      end else begin
        load_shift = shifted;
      end
    end
  endfunction

  function automatic logic [MEM_ADDR_W-1:0] prg_rom_offset(logic [15:0] addr);
    int unsigned a, size, last, off;
    a    = 32'(addr);
    size = prg_rom_bytes();
    last = (size - 32'h4000) & 32'h3FFFF;
    if (prg_mode < PRG_MODE_FIX_FIRST)
      off = (prg_bank & ~32'h7FFF) + (a & 32'h7FFF);
    else if (prg_mode == PRG_MODE_FIX_LAST)
      off = (a < 32'hC000) ? (prg_bank & ~32'h3FFF) + (a & 32'h3FFF) : last + (a & 32'h3FFF);
    else
      off = (a < 32'hC000) ? (a & 32'h3FFF) : (prg_bank & ~32'h3FFF) + (a & 32'h3FFF);
    if (outer_bank) off = off + 32'h40000;
    return MEM_ADDR_W'(off & (size - 1));
  endfunction

  function automatic logic [MEM_ADDR_W-1:0] chr_offset(logic [15:0] addr);
    int unsigned a, off;
    a = addr & 32'h1FFF;
    if (chr_single)
      off = (chr_bank_lo & ~32'h1FFF) + a;
    else if (a < 32'h1000)
      off = (chr_bank_lo & ~32'hFFF) + (a & 32'hFFF);
    else
      off = (chr_bank_hi & ~32'hFFF) + (a & 32'hFFF);
    return MEM_ADDR_W'(off & (chr_mem_bytes() - 1));
  endfunction

  function automatic out_t translate_access(in_t acc);
    out_t r;
    r = '0;
    r.data_out = acc.data;
    case (acc.cmd)
      CMD_CPU_RD, CMD_CPU_WR: begin
        if (acc.addr >= 16'h6000 && acc.addr < 16'h8000) begin
          r.target       = TGT_PRG_RAM;
          r.mem_addr     = MEM_ADDR_W'(acc.addr[12:0]);
          r.write_enable = (acc.cmd == CMD_CPU_WR);
        end else if (acc.addr[15]) begin
          if (acc.cmd == CMD_CPU_RD) begin
            r.target   = TGT_PRG_ROM;
            r.mem_addr = prg_rom_offset(acc.addr);
          end else begin
            serial_load(acc);
          end
        end
      end
      default: begin
        r.target       = TGT_CHR;
        r.mem_addr     = chr_offset(acc.addr);
        r.write_enable = (acc.cmd == CMD_PPU_WR) && mapper_cfg.chr_is_ram;
      end
    endcase
    // mirroring reflects a control commit made by this very beat
    r.mirroring = mirror_mode;
    return r;
  endfunction

  function automatic in_t mk_access(logic [1:0] cmd, logic [15:0] addr, logic [7:0] data,
                                    logic b2b);
    in_t acc;
    acc.cmd = cmd;
    acc.addr = addr;
    acc.data = data;
    acc.back_to_back = b2b;
    return acc;
  endfunction

  function automatic void push_access(in_t acc);
    pending_accesses.push_back(acc);
    queued_count++;
  endfunction

  // five serial writes; only the last one's address picks the register
  function automatic void queue_serial_load(logic [1:0] sel, logic [4:0] value, int broken_at);
    in_t w;
    for (int k = 0; k < 5; k++) begin
      w.cmd = CMD_CPU_WR;
      w.addr = 16'($urandom);
      w.addr[15] = 1'b1;
      if (k == 4) w.addr[14:13] = sel;
      w.data = 8'($urandom);
      w.data[7] = 1'b0;
      w.data[0] = value[k];
      w.back_to_back = 1'b0;
      if (k == broken_at) begin
        if ($urandom_range(0, 1)) w.data[7] = 1'b1;
        else w.back_to_back = 1'b1;
      end
      push_access(w);
    end
  endfunction

  function automatic void queue_directed();
    push_access(mk_access(CMD_CPU_RD, 16'h0000, 8'hA5, 1'b0));
    push_access(mk_access(CMD_CPU_WR, 16'h5FFF, 8'h5A, 1'b0));
    push_access(mk_access(CMD_CPU_RD, 16'h6000, 8'h00, 1'b0));
    push_access(mk_access(CMD_CPU_WR, 16'h7FFF, 8'hFF, 1'b0));
    push_access(mk_access(CMD_CPU_RD, 16'h8000, 8'h00, 1'b0));
    push_access(mk_access(CMD_CPU_RD, 16'hFFFF, 8'hFF, 1'b1));
    push_access(mk_access(CMD_CPU_WR, 16'h8000, 8'h80, 1'b0));
    // vertical mirroring, first bank fixed, single 8K CHR bank
    queue_serial_load(SEL_CONTROL, 5'h0A, -1);
    push_access(mk_access(CMD_CPU_WR, 16'hE000, 8'h01, 1'b1));
    queue_serial_load(SEL_PRG, 5'h1F, -1);
    push_access(mk_access(CMD_CPU_RD, 16'hC123, 8'h00, 1'b0));
    push_access(mk_access(CMD_CPU_RD, 16'h8001, 8'h00, 1'b0));
    queue_serial_load(SEL_CHR0, 5'h13, -1);
    push_access(mk_access(CMD_PPU_RD, 16'h1FFF, 8'h00, 1'b0));
    push_access(mk_access(CMD_PPU_WR, 16'hF000, 8'h3C, 1'b0));
    push_access(mk_access(CMD_PPU_RD, 16'h0000, 8'hFF, 1'b0));
  endfunction

  function automatic void queue_random(int n);
    int made, pick;
    in_t acc;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      acc = IN_W'($urandom);
      if (pick < 35) begin
        queue_serial_load(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                          ($urandom_range(0, 7) == 0) ? $urandom_range(0, 4) : -1);
        made += 5;
      end else if (pick < 80) begin
        case ($urandom_range(0, 2))
          0: begin
            acc.cmd = CMD_CPU_RD;
            acc.addr[15] = 1'b1;
          end
          1: begin
            acc.cmd = $urandom_range(0, 1) ? CMD_CPU_WR : CMD_CPU_RD;
            acc.addr[15:13] = 3'b011;
          end
          default: begin
            acc.cmd = $urandom_range(0, 1) ? CMD_PPU_WR : CMD_PPU_RD;
          end
        endcase
        push_access(acc);
        made++;
      end else begin
        push_access(acc);
        made++;
      end
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PRG_SIZE:   mapper_cfg.prg_size_log2 = value[4:0];
      REG_CHR_SIZE:   mapper_cfg.chr_size_log2 = value[4:0];
      REG_CHR_IS_RAM: mapper_cfg.chr_is_ram    = value[0];
      default:        mapper_cfg.four_screen   = value[0];
    endcase
  endtask

  // unused upper bits carry noise; only the field width is kept
  task automatic set_mapper_config(logic [4:0] prg, logic [4:0] chr, logic ram, logic fs);
    write_reg(REG_PRG_SIZE,    ($urandom & 32'hFFFF_FFE0) | 32'(prg));
    write_reg(REG_CHR_SIZE,    ($urandom & 32'hFFFF_FFE0) | 32'(chr));
    write_reg(REG_CHR_IS_RAM,  ($urandom & 32'hFFFF_FFFE) | 32'(ram));
    write_reg(REG_FOUR_SCREEN, ($urandom & 32'hFFFF_FFFE) | 32'(fs));
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (accepted_count != queued_count || expected_beats.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // sender: bursts of beats separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_beats.push_back(translate_access(in_data));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_accesses.size() > 0) begin
          in_data  <= pending_accesses.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            case ($urandom_range(0, 7))
              0, 1, 2: gap_left = 0;
              7:       gap_left = $urandom_range(10, 25);
              default: gap_left = $urandom_range(1, 6);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall style is picked anew at the end of each random epoch
  int stall_style = 0;
  int stall_epoch = 0;

  always @(posedge clk) begin
    if (stall_epoch == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_epoch = $urandom_range(20, 150);
    end else begin
      stall_epoch--;
    end
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 9) < 3);
      2:       out_stall <= ((stall_epoch % 5) < 2);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  out_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", 32'(out_data), '0);
      end else begin
        want = expected_beats.pop_front();
        if (out_data.target !== want.target)
          report_mismatch("target", 32'(out_data.target), 32'(want.target));
        if (out_data.mem_addr !== want.mem_addr)
          report_mismatch("mem_addr", 32'(out_data.mem_addr), 32'(want.mem_addr));
        if (out_data.write_enable !== want.write_enable)
          report_mismatch("write_enable", 32'(out_data.write_enable),
                          32'(want.write_enable));
        if (out_data.data_out !== want.data_out)
          report_mismatch("data_out", 32'(out_data.data_out), 32'(want.data_out));
        if (out_data.mirroring !== want.mirroring)
          report_mismatch("mirroring", 32'(out_data.mirroring), 32'(want.mirroring));
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || psel || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("serial_bank_switch_mapper regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_mapper_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: queue_directed();
        1: set_mapper_config(5'd19, 5'd17, 1'b0, 1'b0);
        2: set_mapper_config(5'd14, 5'd13, 1'b1, 1'b1);
        3: set_mapper_config(5'd31, 5'd31, 1'b0, 1'b1);
        4: set_mapper_config(5'd0, 5'd0, 1'b1, 1'b0);
        5: set_mapper_config(5'd15, 5'd16, 1'b0, 1'b0);
        default: begin
          set_mapper_config($urandom_range(0, 1) ? 5'd19 : 5'($urandom_range(0, 31)),
                            5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
        end
      endcase
      queue_random(RANDOM_PER_PHASE);
      wait_drained();
    end
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("serial_bank_switch_mapper regression: pass");
    end else begin
      $display("serial_bank_switch_mapper regression: fail");
    end
    $finish;
  end

endmodule
